// ===== src/lzm_pkg.sv =====
package lzm_pkg;

    // number of layers and stack positions
    localparam int NUM_LAYERS = 256;
    localparam int ID_W       = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    // free-layer search runs over groups of sixteen in-use marks
    localparam int GRP_SIZE  = 16;
    localparam int GRP_W     = 4;
    localparam int NUM_GRP   = (NUM_LAYERS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_SEL_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

    // hidden height / empty stack
    localparam logic signed [8:0] HEIGHT_NONE = -9'sd1;
    localparam logic signed [9:0] POS_NONE    = -10'sd1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_SET     = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_NOT_USED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PLAN,
        S_APPLY
    } t_state;

    // broadcast to every stack cell
    typedef struct packed {
        logic              apply;
        logic              from_left;
        logic signed [9:0] lo;
        logic signed [9:0] hi;
        logic              load;
        logic [7:0]        load_pos;
        logic [7:0]        load_id;
    } t_cell_ctrl;

endpackage

// ===== src/lzm_channels.sv =====
interface lzm_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [7:0]        layer_id;
    logic signed [8:0] new_height;

    modport source (output valid, output opcode, output layer_id, output new_height,
                    input ready);
    modport sink   (input valid, input opcode, input layer_id, input new_height,
                    output ready);
endinterface

interface lzm_res_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [7:0]        given_id;
    logic signed [8:0] final_height;
    logic              redraw;
    logic [8:0]        map_from;
    logic [7:0]        draw_from;
    logic signed [8:0] draw_to;
    logic signed [8:0] top_after;

    modport source (output valid, output status, output given_id, output final_height,
                    output redraw, output map_from, output draw_from, output draw_to,
                    output top_after, input ready);
    modport sink   (input valid, input status, input given_id, input final_height,
                    input redraw, input map_from, input draw_from, input draw_to,
                    input top_after, output ready);
endinterface

// ===== src/layer_zorder_manager.sv =====
// layer z-order manager
//
// keeps the stacking order of display layers in a row of stack cells, one
// per position, plus an in-use mark per layer and the top index.
// i_cmd carries one command per transfer: allocate, set height or release.
// o_res returns exactly one result per command with status, claimed layer,
// final height, the redraw ranges and the top index after the command.
// a command is taken only when the block is idle; it then passes through
// three steps: matching the layer id against all cells, planning the move
// and applying it, with the match result and the plan each registered, and
// the block takes no new command until the apply step is done; the result
// is loaded into the output register when the move is applied.
// the result sits in an output register; the next command is taken while it
// waits, but a finished command holds in the apply step until the register
// is free, so a stalled receiver stalls the block after one more command.
// reset (synchronous, active low) empties the stack, frees every layer and
// drops any pending result; stack cell contents are not cleared since a
// position above top is never read.
module layer_zorder_manager (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzm_cmd_if.sink    i_cmd,
    lzm_res_if.source  o_res
);

    localparam int N = lzm_pkg::NUM_LAYERS;

    // control state
    lzm_pkg::t_state              r_state;
    lzm_pkg::t_state              n_state;
    logic signed [8:0]            r_top;
    logic [N-1:0]                 r_in_use;
    logic                         r_out_valid;

    // latched command
    logic [1:0]                   r_op;
    logic [7:0]                   r_id;
    logic signed [8:0]            r_req;

    // match step results
    logic signed [8:0]            r_old;
    logic                         r_valid;
    logic signed [8:0]            w_old;
    logic                         w_valid;
    logic [7:0]                   w_old_or;
    logic                         w_hit;

    // free layer search
    logic                         w_free_any;
    logic [7:0]                   w_free_id;

    // plan step
    lzm_pkg::t_cell_ctrl          r_ctrl;
    lzm_pkg::t_cell_ctrl          n_ctrl;
    logic [1:0]                   r_p_status, n_p_status;
    logic [7:0]                   r_p_given, n_p_given;
    logic signed [8:0]            r_p_fh, n_p_fh;
    logic                         r_p_redraw, n_p_redraw;
    logic [8:0]                   r_p_mfrom, n_p_mfrom;
    logic [7:0]                   r_p_dfrom, n_p_dfrom;
    logic signed [8:0]            r_p_dto, n_p_dto;
    logic signed [8:0]            r_p_top, n_p_top;
    logic                         r_p_set, n_p_set;
    logic                         r_p_clr, n_p_clr;
    logic [lzm_pkg::ID_W-1:0]     r_p_idx, n_p_idx;

    // output register
    logic [1:0]                   r_o_status;
    logic [7:0]                   r_o_given;
    logic signed [8:0]            r_o_fh;
    logic                         r_o_redraw;
    logic [8:0]                   r_o_mfrom;
    logic [7:0]                   r_o_dfrom;
    logic signed [8:0]            r_o_dto;
    logic signed [8:0]            r_o_top;

    // handshake and apply strobe
    logic                         w_cmd_xfer;
    logic                         w_fire;
    lzm_pkg::t_cell_ctrl          w_ctrl;

    // stack cells
    logic [7:0]                   w_cell_id [N];
    logic [N-1:0]                 w_match;

    assign w_cmd_xfer = i_cmd.valid && i_cmd.ready;

    // ---------------------------------------------------------------
    // state machine
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_cmd.ready = 1'b0;
        w_fire      = 1'b0;
        case (r_state)
            lzm_pkg::S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) n_state = lzm_pkg::S_LOOK;
            end
            lzm_pkg::S_LOOK: begin
                n_state = lzm_pkg::S_PLAN;
            end
            lzm_pkg::S_PLAN: begin
                n_state = lzm_pkg::S_APPLY;
            end
            lzm_pkg::S_APPLY: begin
                // wait for the output register to drain
                if (!r_out_valid || o_res.ready) begin
                    w_fire  = 1'b1;
                    n_state = lzm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzm_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // row of stack cells, each handing its id to both neighbors
    // ---------------------------------------------------------------
    always_comb begin
        w_ctrl       = r_ctrl;
        w_ctrl.apply = w_fire;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic [7:0] w_left;
        logic [7:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_id[k-1];
        end

        if (k == N - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_id[k+1];
        end

        lzm_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (8'(k)),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_top   (r_top),
            .i_key   (r_id),
            .o_id    (w_cell_id[k]),
            .o_match (w_match[k])
        );
    end

    lzm_free_find u_free (
        .i_clk    (i_clk),
        .i_in_use (r_in_use),
        .o_any    (w_free_any),
        .o_id     (w_free_id)
    );

    // ---------------------------------------------------------------
    // match step: current height of the addressed layer
    // ---------------------------------------------------------------
    always_comb begin
        w_old_or = '0;
        w_hit    = 1'b0;
        for (int k = 0; k < N; k++) begin
            if (w_match[k]) begin
                w_old_or = w_old_or | 8'(k);
                w_hit    = 1'b1;
            end
        end
        // at most one shown position holds a given layer
        w_old   = w_hit ? $signed({1'b0, w_old_or}) : lzm_pkg::HEIGHT_NONE;
        w_valid = (9'(r_id) < 9'(N)) && r_in_use[r_id[lzm_pkg::ID_W-1:0]];
    end

    // ---------------------------------------------------------------
    // plan step: clamp, pick the shift range and the redraw ranges
    // ---------------------------------------------------------------
    always_comb begin
        logic signed [9:0] w_o;
        logic signed [9:0] w_t;
        logic signed [9:0] w_lim;
        logic signed [9:0] w_h;
        logic              w_move;

        w_o    = $signed({r_old[8], r_old});
        w_t    = $signed({r_top[8], r_top});
        w_lim  = (w_o < 10'sd0) ? (w_t + 10'sd1) : w_t;
        w_h    = $signed({r_req[8], r_req});
        w_move = 1'b0;

        // default: nothing shifts (empty range)
        n_ctrl.apply     = 1'b0;
        n_ctrl.from_left = 1'b0;
        n_ctrl.lo        = 10'sd1;
        n_ctrl.hi        = 10'sd0;
        n_ctrl.load      = 1'b0;
        n_ctrl.load_pos  = '0;
        n_ctrl.load_id   = r_id;

        n_p_status = lzm_pkg::STS_OK;
        n_p_given  = '0;
        n_p_fh     = lzm_pkg::HEIGHT_NONE;
        n_p_redraw = 1'b0;
        n_p_mfrom  = '0;
        n_p_dfrom  = '0;
        n_p_dto    = lzm_pkg::HEIGHT_NONE;
        n_p_top    = r_top;
        n_p_set    = 1'b0;
        n_p_clr    = 1'b0;
        n_p_idx    = r_id[lzm_pkg::ID_W-1:0];

        case (r_op)
            lzm_pkg::OP_ALLOC: begin
                if (w_free_any) begin
                    n_p_given = w_free_id;
                    n_p_set   = 1'b1;
                    n_p_idx   = w_free_id[lzm_pkg::ID_W-1:0];
                end else begin
                    n_p_status = lzm_pkg::STS_NO_FREE;
                end
            end
            lzm_pkg::OP_SET: begin
                if (!r_valid) begin
                    n_p_status = lzm_pkg::STS_NOT_USED;
                end else begin
                    w_move = 1'b1;
                    if (w_h > w_lim) w_h = w_lim;
                    if (w_h < lzm_pkg::POS_NONE) w_h = lzm_pkg::POS_NONE;
                    n_p_fh = 9'(w_h);
                end
            end
            lzm_pkg::OP_RELEASE: begin
                if (!r_valid) begin
                    n_p_status = lzm_pkg::STS_NOT_USED;
                end else begin
                    // hide first, then free
                    w_move  = 1'b1;
                    w_h     = lzm_pkg::POS_NONE;
                    n_p_clr = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_move) begin
            if (w_o > w_h) begin
                n_p_redraw = 1'b1;
                if (w_h >= 10'sd0) begin
                    // lowering: positions above the target move up one
                    n_ctrl.from_left = 1'b1;
                    n_ctrl.lo        = w_h + 10'sd1;
                    n_ctrl.hi        = w_o;
                    n_ctrl.load      = 1'b1;
                    n_ctrl.load_pos  = 8'(w_h);
                    n_p_mfrom        = 9'(w_h + 10'sd1);
                    n_p_dfrom        = 8'(w_h + 10'sd1);
                    n_p_dto          = 9'(w_o);
                end else begin
                    // hiding: positions above close the gap
                    n_ctrl.from_left = 1'b0;
                    n_ctrl.lo        = w_o;
                    n_ctrl.hi        = w_t - 10'sd1;
                    n_p_top          = 9'(w_t - 10'sd1);
                    n_p_dto          = 9'(w_o - 10'sd1);
                end
            end else if (w_o < w_h) begin
                n_p_redraw      = 1'b1;
                n_ctrl.load     = 1'b1;
                n_ctrl.load_pos = 8'(w_h);
                n_p_mfrom       = 9'(w_h);
                n_p_dfrom       = 8'(w_h);
                n_p_dto         = 9'(w_h);
                if (w_o >= 10'sd0) begin
                    // raising a shown layer: positions in between move down
                    n_ctrl.from_left = 1'b0;
                    n_ctrl.lo        = w_o;
                    n_ctrl.hi        = w_h - 10'sd1;
                end else begin
                    // showing a hidden layer: positions from target up move up
                    n_ctrl.from_left = 1'b1;
                    n_ctrl.lo        = w_h + 10'sd1;
                    n_ctrl.hi        = w_t + 10'sd1;
                    n_p_top          = 9'(w_t + 10'sd1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= lzm_pkg::HEIGHT_NONE;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_top <= r_p_top;
                if (r_p_set) r_in_use[r_p_idx] <= 1'b1;
                if (r_p_clr) r_in_use[r_p_idx] <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_cmd_xfer) begin
            r_op  <= i_cmd.opcode;
            r_id  <= i_cmd.layer_id;
            r_req <= i_cmd.new_height;
        end
        if (r_state == lzm_pkg::S_LOOK) begin
            r_old   <= w_old;
            r_valid <= w_valid;
        end
        if (r_state == lzm_pkg::S_PLAN) begin
            r_ctrl     <= n_ctrl;
            r_p_status <= n_p_status;
            r_p_given  <= n_p_given;
            r_p_fh     <= n_p_fh;
            r_p_redraw <= n_p_redraw;
            r_p_mfrom  <= n_p_mfrom;
            r_p_dfrom  <= n_p_dfrom;
            r_p_dto    <= n_p_dto;
            r_p_top    <= n_p_top;
            r_p_set    <= n_p_set;
            r_p_clr    <= n_p_clr;
            r_p_idx    <= n_p_idx;
        end
        if (w_fire) begin
            r_o_status <= r_p_status;
            r_o_given  <= r_p_given;
            r_o_fh     <= r_p_fh;
            r_o_redraw <= r_p_redraw;
            r_o_mfrom  <= r_p_mfrom;
            r_o_dfrom  <= r_p_dfrom;
            r_o_dto    <= r_p_dto;
            r_o_top    <= r_p_top;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_o_status;
    assign o_res.given_id     = r_o_given;
    assign o_res.final_height = r_o_fh;
    assign o_res.redraw       = r_o_redraw;
    assign o_res.map_from     = r_o_mfrom;
    assign o_res.draw_from    = r_o_dfrom;
    assign o_res.draw_to      = r_o_dto;
    assign o_res.top_after    = r_o_top;

endmodule

// ===== src/lzm_cell.sv =====
module lzm_cell (
    input  logic                   i_clk,
    input  logic [7:0]             i_pos,
    input  lzm_pkg::t_cell_ctrl    i_ctrl,
    input  logic [7:0]             i_left,
    input  logic [7:0]             i_right,
    input  logic signed [8:0]      i_top,
    input  logic [7:0]             i_key,
    output logic [7:0]             o_id,
    output logic                   o_match
);

    logic [7:0]        r_id;
    logic [7:0]        n_id;
    logic signed [9:0] w_pos;
    logic signed [9:0] w_top;
    logic              w_in_range;

    assign w_pos      = $signed({2'b00, i_pos});
    assign w_top      = $signed({i_top[8], i_top});
    assign w_in_range = (w_pos >= i_ctrl.lo) && (w_pos <= i_ctrl.hi);

    always_comb begin
        n_id = r_id;
        if (i_ctrl.apply) begin
            if (i_ctrl.load && (i_pos == i_ctrl.load_pos)) begin
                n_id = i_ctrl.load_id;
            end else if (w_in_range) begin
                n_id = i_ctrl.from_left ? i_left : i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    // only positions at or below top hold a shown layer
    assign o_id    = r_id;
    assign o_match = (w_pos <= w_top) && (r_id == i_key);

endmodule

// ===== src/lzm_free_find.sv =====
module lzm_free_find (
    input  logic                           i_clk,
    input  logic [lzm_pkg::NUM_LAYERS-1:0] i_in_use,
    output logic                           o_any,
    output logic [7:0]                     o_id
);

    logic                         r_grp_any [lzm_pkg::NUM_GRP];
    logic [lzm_pkg::GRP_W-1:0]    r_grp_idx [lzm_pkg::NUM_GRP];
    logic                         n_grp_any [lzm_pkg::NUM_GRP];
    logic [lzm_pkg::GRP_W-1:0]    n_grp_idx [lzm_pkg::NUM_GRP];
    logic [lzm_pkg::GRP_SEL_W-1:0] w_sel;

    // first stage: lowest free mark inside each group
    always_comb begin
        int idx;
        for (int g = 0; g < lzm_pkg::NUM_GRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_idx[g] = '0;
            for (int b = lzm_pkg::GRP_SIZE - 1; b >= 0; b--) begin
                idx = g * lzm_pkg::GRP_SIZE + b;
                if (idx < lzm_pkg::NUM_LAYERS) begin
                    if (!i_in_use[idx]) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_idx[g] = lzm_pkg::GRP_W'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < lzm_pkg::NUM_GRP; g++) begin
            r_grp_any[g] <= n_grp_any[g];
            r_grp_idx[g] <= n_grp_idx[g];
        end
    end

    // second stage: lowest group with a free mark
    always_comb begin
        o_any = 1'b0;
        w_sel = '0;
        for (int g = lzm_pkg::NUM_GRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                o_any = 1'b1;
                w_sel = lzm_pkg::GRP_SEL_W'(g);
            end
        end
    end

    assign o_id = 8'({w_sel, r_grp_idx[w_sel]});

endmodule

// ===== verif/tb_layer_zorder_manager.sv =====
`timescale 1ns / 100ps

module tb_layer_zorder_manager;
    import lzm_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          HIDDEN       = HEIGHT_NONE;
    // the one opcode value with no command behind it
    localparam logic [1:0]  OP_SPARE     = 2'd3;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } t_sink_mode;

    typedef struct packed {
        t_status           status;
        logic [7:0]        given_id;
        logic signed [8:0] final_height;
        logic              redraw;
        logic [8:0]        map_from;
        logic [7:0]        draw_from;
        logic signed [8:0] draw_to;
        logic signed [8:0] top_after;
    } t_zreport;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzm_cmd_if cmd_ch ();
    lzm_res_if res_ch ();

    layer_zorder_manager dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the layer stack
    logic [7:0] pos_layer   [NUM_LAYERS];
    int         layer_ht    [NUM_LAYERS];
    bit         layer_taken [NUM_LAYERS];
    int         top_pos;

    t_zreport   pending_reports[$];
    int         mismatch_cnt = 0;
    int         reports_seen = 0;
    int         cycle_cnt    = 0;

    // traffic shaping
    bit         src_gaps   = 1'b1;
    int         burst_left = 0;
    t_sink_mode sink_mode  = SINK_OPEN;
    int         hold_req   = 0;

    function automatic void clear_stack();
        int i;
        for (i = 0; i < NUM_LAYERS; i++) begin
            pos_layer[i]   = '0;
            layer_ht[i]    = HIDDEN;
            layer_taken[i] = 1'b0;
        end
        top_pos = HIDDEN;
    endfunction

    // moves one layer to its clamped height, shifting the layers in between
    function automatic int restack(input int id, input int req, output bit rd,
                                   output int mfrom, output int dfrom, output int dto);
        int old_h, ceil_h, h, k;
        old_h  = layer_ht[id];
        ceil_h = (old_h < 0) ? top_pos + 1 : top_pos;
        h      = req;
        if (h > ceil_h) h = ceil_h;
        if (h < HIDDEN) h = HIDDEN;
        layer_ht[id] = h;
        rd = 1'b0; mfrom = 0; dfrom = 0; dto = HIDDEN;
        if (old_h > h) begin
            if (h >= 0) begin
                for (k = old_h; k > h; k--) begin
                    pos_layer[k] = pos_layer[k-1];
                    layer_ht[pos_layer[k]] = k;
                end
                pos_layer[h] = 8'(id);
                mfrom = h + 1; dfrom = h + 1; dto = old_h;
            end else begin
                // hiding: everything above drops by one
                for (k = old_h; k < top_pos; k++) begin
                    pos_layer[k] = pos_layer[k+1];
                    layer_ht[pos_layer[k]] = k;
                end
                top_pos--;
                mfrom = 0; dfrom = 0; dto = old_h - 1;
            end
            rd = 1'b1;
        end else if (old_h < h) begin
            if (old_h >= 0) begin
                for (k = old_h; k < h; k++) begin
                    pos_layer[k] = pos_layer[k+1];
                    layer_ht[pos_layer[k]] = k;
                end
            end else begin
                // showing: everything from h up rises by one
                for (k = top_pos; k >= h; k--) begin
                    pos_layer[k+1] = pos_layer[k];
                    layer_ht[pos_layer[k+1]] = k + 1;
                end
                top_pos++;
            end
            pos_layer[h] = 8'(id);
            mfrom = h; dfrom = h; dto = h;
            rd = 1'b1;
        end
        return h;
    endfunction

    function automatic t_zreport zorder_apply(input logic [1:0] op, input logic [7:0] id,
                                              input logic signed [8:0] req);
        t_zreport r;
        bit       rd;
        int       mfrom, dfrom, dto, fh, i;
        bit       live;
        r = '0;
        rd = 1'b0; mfrom = 0; dfrom = 0; dto = HIDDEN; fh = HIDDEN;
        live = layer_taken[id];
        r.status = STS_OK;
        case (op)
            OP_ALLOC: begin
                r.status = STS_NO_FREE;
                for (i = 0; i < NUM_LAYERS; i++) begin
                    if (!layer_taken[i]) begin
                        layer_taken[i] = 1'b1;
                        layer_ht[i]    = HIDDEN;
                        r.given_id     = 8'(i);
                        r.status       = STS_OK;
                        break;
                    end
                end
            end
            OP_SET: begin
                if (!live) r.status = STS_NOT_USED;
                else fh = restack(id, int'(req), rd, mfrom, dfrom, dto);
            end
            OP_RELEASE: begin
                if (!live) begin
                    r.status = STS_NOT_USED;
                end else begin
                    if (layer_ht[id] >= 0) void'(restack(id, HIDDEN, rd, mfrom, dfrom, dto));
                    layer_taken[id] = 1'b0;
                end
            end
            default: ;
        endcase
        r.final_height = 9'(fh);
        r.redraw       = rd;
        r.map_from     = 9'(mfrom);
        r.draw_from    = 8'(dfrom);
        r.draw_to      = 9'(dto);
        r.top_after    = 9'(top_pos);
        return r;
    endfunction

    function automatic int taken_count();
        int i, n;
        n = 0;
        for (i = 0; i < NUM_LAYERS; i++) n += layer_taken[i];
        return n;
    endfunction

    function automatic logic [7:0] pick_taken_layer();
        logic [7:0] ids[$];
        int         i;
        for (i = 0; i < NUM_LAYERS; i++) if (layer_taken[i]) ids.push_back(8'(i));
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // requested heights: mostly near the live stack, some extremes and noise
    function automatic logic signed [8:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return HEIGHT_NONE;
            1:       return 9'sd255;
            2:       return -9'sd256;
            3, 4:    return 9'($urandom);
            default: return 9'(int'($urandom_range(0, top_pos + 2)) - 1);
        endcase
    endfunction

    // one command transfer; the expected report is queued at acceptance
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] id,
                            input logic signed [8:0] req);
        int gap;
        if (src_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.layer_id   <= id;
        cmd_ch.new_height <= req;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pending_reports.push_back(zorder_apply(op, id, req));
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch in report %0d, %s: expected %0d, got %0d",
                         reports_seen, fname, want, got);
        end
    endtask

    // result side: compare every report with the oldest expectation
    always @(posedge i_clk) begin
        t_zreport want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("report %0d arrived with nothing expected", reports_seen);
            end else begin
                want = pending_reports.pop_front();
                check_field("status", int'(want.status), int'(res_ch.status));
                check_field("given_id", int'(want.given_id), int'(res_ch.given_id));
                check_field("final_height", int'(want.final_height),
                            int'(res_ch.final_height));
                check_field("redraw", int'(want.redraw), int'(res_ch.redraw));
                check_field("map_from", int'(want.map_from), int'(res_ch.map_from));
                check_field("draw_from", int'(want.draw_from), int'(res_ch.draw_from));
                check_field("draw_to", int'(want.draw_to), int'(res_ch.draw_to));
                check_field("top_after", int'(want.top_after), int'(res_ch.top_after));
            end
            reports_seen++;
        end
    end

    // receiver: stall pattern of its own, plus long holds on request
    initial begin
        int hold_cnt;
        int sink_phase;
        hold_cnt   = 0;
        sink_phase = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                res_ch.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_RANDOM:  res_ch.ready <= ($urandom_range(0, 3) != 0);
                    SINK_PATTERN: res_ch.ready <= ((sink_phase % 13) < 8);
                    default:      res_ch.ready <= 1'b1;
                endcase
            end
            sink_phase++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // extremes of the fields, every command and each corner case
    task automatic test_directed();
        send_cmd(OP_SET, 8'd0, 9'sd0);             // set on a free layer
        send_cmd(OP_RELEASE, 8'd255, -9'sd256);    // release of a free layer
        send_cmd(OP_SPARE, 8'hff, 9'h1ff);         // spare opcode
        send_cmd(OP_ALLOC, 8'd0, 9'sd0);
        send_cmd(OP_ALLOC, 8'd255, 9'sd255);
        send_cmd(OP_ALLOC, 8'd0, -9'sd1);
        send_cmd(OP_ALLOC, 8'd0, 9'sd0);
        send_cmd(OP_SET, 8'd0, 9'sd255);           // show on empty stack, clamps to 0
        send_cmd(OP_SET, 8'd1, -9'sd256);          // hidden stays hidden
        send_cmd(OP_SET, 8'd1, 9'sd255);           // show on top
        send_cmd(OP_SET, 8'd2, 9'sd0);             // insert at the bottom
        send_cmd(OP_SET, 8'd3, 9'sd1);             // insert in the middle
        send_cmd(OP_SET, 8'd3, 9'sd255);           // raise a shown layer, clamps to top
        send_cmd(OP_SET, 8'd3, 9'sd0);             // lower to the bottom
        send_cmd(OP_SET, 8'd1, 9'(layer_ht[1]));   // same height, nothing moves
        send_cmd(OP_SET, 8'd2, HEIGHT_NONE);       // hide
        send_cmd(OP_SET, 8'd0, -9'sd256);          // hide via clamp
        send_cmd(OP_RELEASE, 8'd1, 9'sd0);         // release a shown layer
        send_cmd(OP_RELEASE, 8'd2, 9'sd0);         // release a hidden layer
        send_cmd(OP_RELEASE, 8'd2, 9'sd0);         // release twice
        send_cmd(OP_SPARE, 8'h00, 9'h000);
        send_cmd(OP_ALLOC, 8'd0, 9'sd0);           // reuses the lowest free layer
        send_cmd(OP_SET, 8'd128, 9'sd1);           // high id, never claimed
    endtask

    // small pool of layers, mostly legal traffic with some noise
    task automatic test_random_mix(input int n);
        int k, r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_cmd(OP_SPARE, 8'($urandom), 9'($urandom));
            else if (r < 9)
                send_cmd($urandom_range(0, 1) ? OP_SET : OP_RELEASE,
                         8'($urandom), 9'($urandom));
            else if (taken_count() == 0 || (r < 30 && taken_count() < 24))
                send_cmd(OP_ALLOC, 8'($urandom), 9'($urandom));
            else if (r < 42)
                send_cmd(OP_RELEASE, pick_taken_layer(), 9'($urandom));
            else
                send_cmd(OP_SET, pick_taken_layer(), pick_height());
        end
    endtask

    // claim every layer, run out, then show them all and shuffle
    task automatic test_full_stack(input int shuffles);
        int k;
        while (taken_count() < NUM_LAYERS)
            send_cmd(OP_ALLOC, 8'($urandom), 9'($urandom));
        send_cmd(OP_ALLOC, 8'd0, 9'sd0);
        send_cmd(OP_ALLOC, 8'd255, -9'sd1);
        for (k = 0; k < NUM_LAYERS; k++) begin
            if (layer_ht[k] < 0)
                send_cmd(OP_SET, 8'(k), (k % 17 == 0) ? 9'sd255
                                        : 9'($urandom_range(0, top_pos + 1)));
        end
        for (k = 0; k < shuffles; k++)
            send_cmd(OP_SET, pick_taken_layer(), pick_height());
    endtask

    // receiver holds off while commands keep coming back to back
    task automatic test_backpressure(input int n);
        int k;
        src_gaps = 1'b0;
        hold_req = 400;
        for (k = 0; k < n; k++)
            send_cmd(OP_SET, pick_taken_layer(), pick_height());
        src_gaps = 1'b1;
    endtask

    // tear the stack down in random order
    task automatic test_release_all();
        while (taken_count() > 0)
            send_cmd(OP_RELEASE, pick_taken_layer(), 9'($urandom));
        send_cmd(OP_SET, 8'd7, 9'sd3);
    endtask

    initial begin
        clear_stack();
        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= OP_ALLOC;
        cmd_ch.layer_id   <= '0;
        cmd_ch.new_height <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sink_mode = SINK_RANDOM;
        test_directed();
        test_random_mix(60);

        // fill phase without idling on either side
        src_gaps  = 1'b0;
        sink_mode = SINK_OPEN;
        test_full_stack(0);
        src_gaps  = 1'b1;
        sink_mode = SINK_PATTERN;
        test_full_stack(50);
        test_backpressure(30);

        sink_mode = SINK_RANDOM;
        test_release_all();
        test_random_mix(30);

        cmd_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
